FILE: src/tkmpq_pkg.sv
// Shared types and constants for the two-key minimum priority queue.
package tkmpq_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 32;
    localparam int ID_BITS  = 16;
    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    localparam logic [KEY_BITS-1:0] INF = {KEY_BITS{1'b1}};

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    typedef struct packed {
        logic [ID_BITS-1:0]  id;
        logic [KEY_BITS-1:0] primary;
        logic [KEY_BITS-1:0] secondary;
    } t_entry;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry fresh;
    } t_cell_ctl;

endpackage

FILE: src/tkmpq_cell.sv
// One slot of the sorted shift-register queue.
module tkmpq_cell (
    input  logic                 i_clk,
    input  tkmpq_pkg::t_cell_ctl i_ctl,
    input  logic                 i_occupied,
    input  logic                 i_left_gt,
    input  tkmpq_pkg::t_entry    i_left,
    input  tkmpq_pkg::t_entry    i_right,
    output logic                 o_gt,
    output tkmpq_pkg::t_entry    o_entry,
    output tkmpq_pkg::t_entry    o_next
);
    import tkmpq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // strict compare keeps equal keys in arrival order; an empty slot is larger than anything
    assign o_gt = !i_occupied
                  || ({r_entry.primary, r_entry.secondary}
                      > {i_ctl.fresh.primary, i_ctl.fresh.secondary});

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push) begin
            if (o_gt) begin
                n_entry = i_left_gt ? i_left : i_ctl.fresh;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;

endmodule

FILE: src/two_key_min_priority_queue.sv
// Top level: a row of sorted cells with a registered result stage.
//
// The operations are push, pop-minimum and clear; a new one is
// accepted every cycle as long as the result register is free or is being
// transferred out in the same cycle. A push broadcasts its key to all CAPACITY
// cells, each compares against its own key and either keeps, shifts right or
// takes the new entry; a pop shifts every cell left. The minimum always sits
// in cell 0. The result reports the popped entry, the top key after the
// operation (all ones when empty), the occupancy and a flag for a push
// dropped because the queue was full. Results come out in the cycle after the
// input transfer. No clearing pass is needed after reset.
module two_key_min_priority_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_opcode,
    input  logic [tkmpq_pkg::ID_BITS-1:0]     i_item_id,
    input  logic [tkmpq_pkg::KEY_BITS-1:0]    i_key_primary,
    input  logic [tkmpq_pkg::KEY_BITS-1:0]    i_key_secondary,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_popped_valid,
    output logic [tkmpq_pkg::ID_BITS-1:0]     o_popped_id,
    output logic [tkmpq_pkg::KEY_BITS-1:0]    o_popped_key_primary,
    output logic [tkmpq_pkg::KEY_BITS-1:0]    o_popped_key_secondary,
    output logic [tkmpq_pkg::KEY_BITS-1:0]    o_top_primary,
    output logic [tkmpq_pkg::KEY_BITS-1:0]    o_top_secondary,
    output logic [tkmpq_pkg::CNT_BITS-1:0]    o_occupancy,
    output logic                              o_overflow
);
    import tkmpq_pkg::*;

    logic                r_count_ok;
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;

    logic                r_out_valid;
    logic                n_out_valid;
    logic                r_popped_valid;
    t_entry              r_popped;
    logic [KEY_BITS-1:0] r_top_primary;
    logic [KEY_BITS-1:0] r_top_secondary;
    logic                r_overflow;
    logic [CNT_BITS-1:0] r_occupancy;

    logic      accept;
    logic      full;
    logic      push_en;
    logic      pop_en;
    logic      drop;
    t_cell_ctl ctl;

    logic   [CAPACITY-1:0] gt;
    t_entry                cell_entry [CAPACITY];
    t_entry                cell_next  [CAPACITY];

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign full    = (r_count == CNT_BITS'(CAPACITY));

    always_comb begin
        push_en = 1'b0;
        pop_en  = 1'b0;
        drop    = 1'b0;
        n_count = r_count;
        if (accept) begin
            case (i_opcode)
                OP_PUSH: begin
                    if (full) begin
                        drop = 1'b1;
                    end else begin
                        push_en = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
                OP_POP: begin
                    if (r_count != '0) begin
                        pop_en  = 1'b1;
                        n_count = r_count - 1'b1;
                    end
                end
                OP_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    assign ctl.push            = push_en;
    assign ctl.pop             = pop_en;
    assign ctl.fresh.id        = i_item_id;
    assign ctl.fresh.primary   = i_key_primary;
    assign ctl.fresh.secondary = i_key_secondary;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic   occupied;
        logic   left_gt;
        t_entry left_entry;
        t_entry right_entry;

        assign occupied = (CNT_BITS'(g) < r_count);

        if (g == 0) begin : g_head
            assign left_gt    = 1'b0;
            assign left_entry = ctl.fresh;
        end else begin : g_body
            assign left_gt    = gt[g-1];
            assign left_entry = cell_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_entry = cell_entry[g];
        end else begin : g_inner
            assign right_entry = cell_entry[g+1];
        end

        tkmpq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_occupied (occupied),
            .i_left_gt  (left_gt),
            .i_left     (left_entry),
            .i_right    (right_entry),
            .o_gt       (gt[g]),
            .o_entry    (cell_entry[g]),
            .o_next     (cell_next[g])
        );
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_count_ok  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_count_ok  <= (n_count <= CNT_BITS'(CAPACITY));
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, loaded on every input transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_popped_valid <= pop_en;
            r_popped       <= pop_en ? cell_entry[0] : '0;
            r_overflow     <= drop;
            r_occupancy    <= n_count;
            if (n_count != '0) begin
                r_top_primary   <= cell_next[0].primary;
                r_top_secondary <= cell_next[0].secondary;
            end else begin
                r_top_primary   <= INF;
                r_top_secondary <= INF;
            end
        end
    end

    assign o_valid                = r_out_valid;
    assign o_popped_valid         = r_popped_valid;
    assign o_popped_id            = r_popped.id;
    assign o_popped_key_primary   = r_popped.primary;
    assign o_popped_key_secondary = r_popped.secondary;
    assign o_top_primary          = r_top_primary;
    assign o_top_secondary        = r_top_secondary;
    assign o_occupancy            = r_occupancy;
    assign o_overflow             = r_overflow;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count_ok)
        else $error("queue count beyond capacity");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_occupancy == CNT_BITS'(CAPACITY))
        else $error("overflow reported while queue not full");

    a_pop_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_popped_valid |->
            {o_popped_key_primary, o_popped_key_secondary}
            <= {o_top_primary, o_top_secondary})
        else $error("popped key larger than remaining minimum");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_occupancy == '0 |-> o_top_primary == INF && o_top_secondary == INF)
        else $error("empty queue reports a finite top key");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

FILE: bench/two_key_min_priority_queue_test.sv
// Self-checking testbench for the two-key minimum priority queue.
module two_key_min_priority_queue_test;

    import tkmpq_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;  // unused code, leaves the queue as it is
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam int HOLD_CYCLES = 120;

    typedef struct packed {
        logic                popped_valid;
        logic [ID_BITS-1:0]  popped_id;
        logic [KEY_BITS-1:0] popped_primary;
        logic [KEY_BITS-1:0] popped_secondary;
        logic [KEY_BITS-1:0] top_primary;
        logic [KEY_BITS-1:0] top_secondary;
        logic [CNT_BITS-1:0] occupancy;
        logic                overflow;
    } t_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [1:0]          i_opcode = OP_PUSH;
    logic [ID_BITS-1:0]  i_item_id = '0;
    logic [KEY_BITS-1:0] i_key_primary = '0;
    logic [KEY_BITS-1:0] i_key_secondary = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic                o_popped_valid;
    logic [ID_BITS-1:0]  o_popped_id;
    logic [KEY_BITS-1:0] o_popped_key_primary;
    logic [KEY_BITS-1:0] o_popped_key_secondary;
    logic [KEY_BITS-1:0] o_top_primary;
    logic [KEY_BITS-1:0] o_top_secondary;
    logic [CNT_BITS-1:0] o_occupancy;
    logic                o_overflow;

    t_entry  held_entries[$];     // sorted copy of the queue, minimum first
    t_result pending_results[$];
    int      mismatches = 0;
    int      results_seen = 0;
    int      idle_cycles = 0;
    int      sender_gap_pct = 0;
    int      receiver_stall_pct = 0;
    int      hold_left = 0;
    logic    moved;
    t_result seen;

    two_key_min_priority_queue uut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_opcode               (i_opcode),
        .i_item_id              (i_item_id),
        .i_key_primary          (i_key_primary),
        .i_key_secondary        (i_key_secondary),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_popped_valid         (o_popped_valid),
        .o_popped_id            (o_popped_id),
        .o_popped_key_primary   (o_popped_key_primary),
        .o_popped_key_secondary (o_popped_key_secondary),
        .o_top_primary          (o_top_primary),
        .o_top_secondary        (o_top_secondary),
        .o_occupancy            (o_occupancy),
        .o_overflow             (o_overflow)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // strict lexicographic compare: primary, then secondary
    function automatic bit key_above(input t_entry a, input t_entry b);
        if (a.primary != b.primary)
            return a.primary > b.primary;
        return a.secondary > b.secondary;
    endfunction

    function automatic t_result apply_queue_op(input logic [1:0] op, input t_entry fresh);
        t_result r;
        t_entry  gone;
        int      slot;
        r = '0;
        case (op)
            OP_PUSH: begin
                if (held_entries.size() >= CAPACITY) begin
                    r.overflow = 1'b1;
                end else begin
                    // equal keys queue up behind the ones already held
                    slot = held_entries.size();
                    for (int i = 0; i < held_entries.size(); i++) begin
                        if (key_above(held_entries[i], fresh)) begin
                            slot = i;
                            break;
                        end
                    end
                    held_entries.insert(slot, fresh);
                end
            end
            OP_POP: begin
                if (held_entries.size() > 0) begin
                    gone = held_entries.pop_front();
                    r.popped_valid     = 1'b1;
                    r.popped_id        = gone.id;
                    r.popped_primary   = gone.primary;
                    r.popped_secondary = gone.secondary;
                end
            end
            OP_CLEAR: held_entries.delete();
            default: ;
        endcase
        if (held_entries.size() > 0) begin
            r.top_primary   = held_entries[0].primary;
            r.top_secondary = held_entries[0].secondary;
        end else begin
            r.top_primary   = INF;
            r.top_secondary = INF;
        end
        r.occupancy = CNT_BITS'(held_entries.size());
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 100)
            $display("ERROR result %0d: %s", results_seen, msg);
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
            return;
        end
        want = pending_results.pop_front();
        if (got.popped_valid !== want.popped_valid)
            report_mismatch($sformatf("popped_valid %b, expected %b",
                                      got.popped_valid, want.popped_valid));
        if (got.popped_id !== want.popped_id)
            report_mismatch($sformatf("popped_id %h, expected %h",
                                      got.popped_id, want.popped_id));
        if (got.popped_primary !== want.popped_primary)
            report_mismatch($sformatf("popped_key_primary %h, expected %h",
                                      got.popped_primary, want.popped_primary));
        if (got.popped_secondary !== want.popped_secondary)
            report_mismatch($sformatf("popped_key_secondary %h, expected %h",
                                      got.popped_secondary, want.popped_secondary));
        if (got.top_primary !== want.top_primary)
            report_mismatch($sformatf("top_primary %h, expected %h",
                                      got.top_primary, want.top_primary));
        if (got.top_secondary !== want.top_secondary)
            report_mismatch($sformatf("top_secondary %h, expected %h",
                                      got.top_secondary, want.top_secondary));
        if (got.occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy %0d, expected %0d",
                                      got.occupancy, want.occupancy));
        if (got.overflow !== want.overflow)
            report_mismatch($sformatf("overflow %b, expected %b",
                                      got.overflow, want.overflow));
    endtask

    // Output check first, then input transfer, in one process so the order is fixed.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                results_seen++;
                seen = {o_popped_valid, o_popped_id, o_popped_key_primary,
                        o_popped_key_secondary, o_top_primary, o_top_secondary,
                        o_occupancy, o_overflow};
                check_result(seen);
            end
            if (i_valid && !o_stall) begin
                moved = 1'b1;
                pending_results.insert(pending_results.size(), apply_queue_op(i_opcode,
                    '{id: i_item_id, primary: i_key_primary, secondary: i_key_secondary}));
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // receiver side: long hold when requested, random stalls otherwise
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else begin
            i_stall = ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    task automatic send_op(input logic [1:0] op, input logic [ID_BITS-1:0] id,
                           input logic [KEY_BITS-1:0] kp, input logic [KEY_BITS-1:0] ks);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_gap_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid         = 1'b1;
        i_opcode        = op;
        i_item_id       = id;
        i_key_primary   = kp;
        i_key_secondary = ks;
        do @(posedge i_clk); while (o_stall);
    endtask

    // stop sending and wait until every result has come back
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    // mix of full-range keys and a few small Q16.16 values that force ties
    function automatic logic [KEY_BITS-1:0] rand_key();
        case ($urandom_range(0, 7))
            4, 5:    return KEY_BITS'($urandom_range(0, 3)) << 16;
            6:       return '0;
            7:       return INF;
            default: return KEY_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] rand_op(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return OP_PUSH;
        if (r < 96)
            return OP_POP;
        if (r < 98)
            return OP_CLEAR;
        return OP_NOP;
    endfunction

    task automatic send_random(input int push_pct);
        send_op(rand_op(push_pct), ID_BITS'($urandom), rand_key(), rand_key());
    endtask

    task automatic test_directed();
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        send_op(OP_POP,   16'h1234, 32'h1, 32'h2);        // pop from empty
        send_op(OP_NOP,   16'h0,    32'h0, 32'h0);
        send_op(OP_CLEAR, 16'hffff, INF,   INF);          // clear when empty
        send_op(OP_PUSH,  16'hffff, INF,   INF);
        send_op(OP_PUSH,  16'h0000, 32'h0, 32'h0);
        send_op(OP_PUSH,  16'h0001, 32'h0005_0000, 32'h0000_0007);
        send_op(OP_PUSH,  16'h0002, 32'h0005_0000, 32'h0000_0003);
        send_op(OP_PUSH,  16'h0003, 32'h0005_0000, 32'h0000_0007);  // ties id 1
        send_op(OP_PUSH,  16'h0004, 32'h0005_0000, 32'h0000_0007);
        send_op(OP_PUSH,  16'h5a5a, 32'haaaa_5555, 32'h5555_aaaa);
        send_op(OP_PUSH,  16'ha5a5, 32'h5555_aaaa, 32'haaaa_5555);
        send_op(OP_NOP,   16'hbeef, 32'hdead_beef, 32'hcafe_f00d);
        repeat (8) send_op(OP_POP, 16'h0, 32'h0, 32'h0);
        send_op(OP_POP,   16'h0,    32'h0, 32'h0);        // empty again
        send_op(OP_PUSH,  16'h0010, INF,   32'h0);
        send_op(OP_PUSH,  16'h0011, 32'h0, INF);
        send_op(OP_CLEAR, 16'h0,    32'h0, 32'h0);
        send_op(OP_POP,   16'h0,    32'h0, 32'h0);
        drain();
    endtask

    task automatic test_full_queue();
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        repeat (CAPACITY) send_op(OP_PUSH, ID_BITS'($urandom), rand_key(), rand_key());
        repeat (3) send_random(100);                      // dropped, queue full
        send_op(OP_NOP, ID_BITS'($urandom), rand_key(), rand_key());
        repeat (2) send_op(OP_POP, ID_BITS'($urandom), rand_key(), rand_key());
        repeat (3) send_random(100);
        drain();
    endtask

    task automatic test_random_mix(input int gap_pct, input int stall_pct, input int count);
        int push_pct;
        sender_gap_pct     = gap_pct;
        receiver_stall_pct = stall_pct;
        push_pct           = 60;
        for (int n = 0; n < count; n++) begin
            if (n % 20 == 0)
                push_pct = $urandom_range(25, 85);
            send_random(push_pct);
        end
        drain();
    endtask

    // receiver holds off while items keep coming, so the input side stalls
    task automatic test_backpressure();
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        @(posedge i_clk);
        hold_left = HOLD_CYCLES;
        repeat (30) send_random(70);
        drain();
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_full_queue();
        test_random_mix(0, 0, 70);
        test_random_mix(61, 0, 70);
        test_random_mix(0, 61, 70);
        test_random_mix(26, 26, 70);
        test_backpressure();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/tkmpq_pkg.sv
src/tkmpq_cell.sv
src/two_key_min_priority_queue.sv
bench/two_key_min_priority_queue_test.sv
